/* src/nsf_pkg.sv */
// Package for the NMEA sentence framer: phase and drop-cause codes,
// character constants and the hex digit decoder. No dependencies.
`default_nettype none

package nsf_pkg;

   typedef enum logic [2:0] {
      PH_IDLE = 3'd0,
      PH_BODY = 3'd1,
      PH_HEX1 = 3'd2,
      PH_HEX2 = 3'd3,
      PH_CR   = 3'd4,
      PH_LF   = 3'd5
   } phase_type;

   typedef enum logic [2:0] {
      CAUSE_NONE     = 3'd0,
      CAUSE_OVERLONG = 3'd1,
      CAUSE_BADHEX   = 3'd2,
      CAUSE_MISMATCH = 3'd3,
      CAUSE_LINEEND  = 3'd4
   } cause_type;

   typedef struct packed {
      logic       ok;
      logic [3:0] value;
   } hex_type;

   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_0      = 8'h30;
   localparam logic [7:0] CH_9      = 8'h39;
   localparam logic [7:0] CH_UA     = 8'h41;
   localparam logic [7:0] CH_UF     = 8'h46;
   localparam logic [7:0] CH_LA     = 8'h61;
   localparam logic [7:0] CH_LFCH   = 8'h66;

   function automatic hex_type hex_decode(input logic [7:0] c);
      hex_type    h;
      logic [7:0] d;
      h.ok    = 1'b0;
      h.value = 4'd0;
      d       = 8'd0;
      if (c >= CH_0 && c <= CH_9) begin
         d       = c - CH_0;
         h.ok    = 1'b1;
         h.value = d[3:0];
      end else if (c >= CH_UA && c <= CH_UF) begin
         d       = c - CH_UA + 8'd10;
         h.ok    = 1'b1;
         h.value = d[3:0];
      end else if (c >= CH_LA && c <= CH_LFCH) begin
         d       = c - CH_LA + 8'd10;
         h.ok    = 1'b1;
         h.value = d[3:0];
      end
      return h;
   endfunction

endpackage

`default_nettype wire

/* src/nmea_sentence_framer.sv */
// NMEA 0183 sentence framer: running-XOR checksum and line-end check.
// Uses nsf_pkg for phase codes, drop causes and the hex decoder.
// Each byte passes an input register and then a result register on its way to rsp_tdata.
// Throughput: one byte per cycle while rsp_tready is held high; the phase state updates
// in a single pass per byte.
// Reset: synchronous, active high; clears phase, counters, checksum and both valids.
`default_nettype none

module nmea_sentence_framer #(
   parameter int BODY_MAX = 82
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata    // [0] body_valid, [8:1] body_byte,
                                         // [15:9] body_index, [16] frame_good,
                                         // [23:17] frame_length, [31:24] frame_count,
                                         // [34:32] drop_cause, [39:35] zero
);

   localparam logic [6:0] BodyMax = 7'(BODY_MAX);

   logic                 in_valid_ff, in_valid_in;
   logic [7:0]           in_byte_ff;
   logic                 out_valid_ff, out_valid_in;
   logic [39:0]          out_data_ff, out_data_in;

   nsf_pkg::phase_type   phase_ff, phase_in;
   logic [6:0]           count_ff, count_in;
   logic [7:0]           xor_ff, xor_in;
   logic [7:0]           check_ff, check_in;
   logic [7:0]           good_ff, good_in;

   logic                 advance;
   logic                 step;
   nsf_pkg::hex_type     hex;
   logic [7:0]           check_full;

   logic                 body_valid;
   logic [7:0]           body_byte;
   logic [6:0]           body_index;
   logic                 frame_good;
   logic [6:0]           frame_length;
   nsf_pkg::cause_type   cause;

   assign advance    = !out_valid_ff || rsp_tready;
   assign step       = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;
   assign hex        = nsf_pkg::hex_decode(in_byte_ff);
   assign check_full = check_ff | {4'd0, hex.value};

   // next state
   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      xor_in   = xor_ff;
      check_in = check_ff;
      good_in  = good_ff;
      if (step) begin
         case (phase_ff)
            nsf_pkg::PH_IDLE: begin
               if (in_byte_ff == nsf_pkg::CH_DOLLAR) begin
                  phase_in = nsf_pkg::PH_BODY;
                  count_in = 7'd0;
                  xor_in   = 8'd0;
               end
            end
            nsf_pkg::PH_BODY: begin
               if (count_ff < BodyMax) begin
                  if (in_byte_ff != nsf_pkg::CH_STAR) begin
                     xor_in   = xor_ff ^ in_byte_ff;
                     count_in = count_ff + 7'd1;
                  end else begin
                     phase_in = nsf_pkg::PH_HEX1;
                  end
               end else begin
                  phase_in = nsf_pkg::PH_IDLE;
               end
            end
            nsf_pkg::PH_HEX1: begin
               if (hex.ok) begin
                  check_in = {hex.value, 4'd0};
                  phase_in = nsf_pkg::PH_HEX2;
               end else begin
                  phase_in = nsf_pkg::PH_IDLE;
               end
            end
            nsf_pkg::PH_HEX2: begin
               if (hex.ok) begin
                  check_in = check_full;
                  phase_in = (check_full == xor_ff) ? nsf_pkg::PH_CR : nsf_pkg::PH_IDLE;
               end else begin
                  phase_in = nsf_pkg::PH_IDLE;
               end
            end
            nsf_pkg::PH_CR: begin
               phase_in = (in_byte_ff == nsf_pkg::CH_CR) ? nsf_pkg::PH_LF : nsf_pkg::PH_IDLE;
            end
            nsf_pkg::PH_LF: begin
               if (in_byte_ff == nsf_pkg::CH_LF) begin
                  good_in = good_ff + 8'd1;
               end
               phase_in = nsf_pkg::PH_IDLE;
            end
            default: begin
               phase_in = nsf_pkg::PH_IDLE;
            end
         endcase
      end
   end

   // result fields
   always_comb begin
      body_valid   = 1'b0;
      body_byte    = 8'd0;
      body_index   = 7'd0;
      frame_good   = 1'b0;
      frame_length = 7'd0;
      cause        = nsf_pkg::CAUSE_NONE;
      case (phase_ff)
         nsf_pkg::PH_BODY: begin
            if (count_ff < BodyMax) begin
               if (in_byte_ff != nsf_pkg::CH_STAR) begin
                  body_valid = 1'b1;
                  body_byte  = in_byte_ff;
                  body_index = count_ff;
               end
            end else begin
               cause = nsf_pkg::CAUSE_OVERLONG;
            end
         end
         nsf_pkg::PH_HEX1: begin
            if (!hex.ok) begin
               cause = nsf_pkg::CAUSE_BADHEX;
            end
         end
         nsf_pkg::PH_HEX2: begin
            if (!hex.ok) begin
               cause = nsf_pkg::CAUSE_BADHEX;
            end else if (check_full != xor_ff) begin
               cause = nsf_pkg::CAUSE_MISMATCH;
            end
         end
         nsf_pkg::PH_CR: begin
            if (in_byte_ff != nsf_pkg::CH_CR) begin
               cause = nsf_pkg::CAUSE_LINEEND;
            end
         end
         nsf_pkg::PH_LF: begin
            if (in_byte_ff == nsf_pkg::CH_LF) begin
               frame_good   = 1'b1;
               frame_length = count_ff;
            end else begin
               cause = nsf_pkg::CAUSE_LINEEND;
            end
         end
         default: begin
            body_valid = 1'b0;
         end
      endcase
   end

   // pipeline control
   always_comb begin
      in_valid_in  = in_valid_ff;
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (advance) begin
         in_valid_in  = 1'b0;
         out_valid_in = in_valid_ff;
      end
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
      end
      if (step) begin
         out_data_in = {5'd0, cause, good_in, frame_length, frame_good,
                        body_index, body_byte, body_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         phase_ff     <= nsf_pkg::PH_IDLE;
         count_ff     <= 7'd0;
         xor_ff       <= 8'd0;
         check_ff     <= 8'd0;
         good_ff      <= 8'd0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         xor_ff       <= xor_in;
         check_ff     <= check_in;
         good_ff      <= good_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
      end
      out_data_ff <= out_data_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

`default_nettype wire

/* sim/tb_nmea_sentence_framer.sv */
`timescale 1ns / 100ps
// Testbench for nmea_sentence_framer: streams received bytes through the framer and
// checks every result transfer against a byte-by-byte model of the sentence checker.
// Depends on nsf_pkg and src/nmea_sentence_framer.sv.

module tb_nmea_sentence_framer;

   localparam int BODY_MAX     = 82;
   localparam int ITEM_TARGET  = 1900;
   localparam int CALM_TAIL    = 200;
   localparam int HOLD_AFTER   = 400;
   localparam int HOLD_CYCLES  = 200;
   localparam int DRAIN_CYCLES = 10;
   localparam int CYCLE_LIMIT  = 400000;

   typedef enum int {
      FAULT_NONE,
      FAULT_SUM,
      FAULT_HEX_HI,
      FAULT_HEX_LO,
      FAULT_CR,
      FAULT_LF
   } fault_type;

   typedef struct packed {
      logic [4:0] pad;
      logic [2:0] cause;
      logic [7:0] count;
      logic [6:0] length;
      logic       good;
      logic [6:0] index;
      logic [7:0] data;
      logic       valid;
   } frame_result_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;

   logic [7:0]       pending_bytes[$];
   frame_result_type frames_expected[$];
   int               item_total     = 0;
   int               total_bytes    = 0;
   int               items_sent     = 0;
   int               cycle_count    = 0;
   int               mismatch_count = 0;
   int               send_gap       = 0;
   int               stall_left     = 0;
   int               hold_left      = 0;
   bit               hold_done      = 1'b0;
   wire              calm           = (items_sent + CALM_TAIL >= total_bytes);

   nsf_pkg::phase_type fr_phase      = nsf_pkg::PH_IDLE;
   logic [6:0]         fr_body_count = 7'd0;
   logic [7:0]         fr_xor        = 8'h00;
   logic [7:0]         fr_check      = 8'h00;
   logic [7:0]         fr_good_count = 8'h00;

   nmea_sentence_framer #(
      .BODY_MAX (BODY_MAX)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #2 clock = ~clock;

   function automatic logic [4:0] nibble_of(input logic [7:0] c);
      logic [7:0] d;
      d = 8'd0;
      if (c >= nsf_pkg::CH_0 && c <= nsf_pkg::CH_9) begin
         d = c - nsf_pkg::CH_0;
      end else if (c >= nsf_pkg::CH_UA && c <= nsf_pkg::CH_UF) begin
         d = c - nsf_pkg::CH_UA + 8'd10;
      end else if (c >= nsf_pkg::CH_LA && c <= nsf_pkg::CH_LFCH) begin
         d = c - nsf_pkg::CH_LA + 8'd10;
      end else begin
         return 5'd0;
      end
      return {1'b1, d[3:0]};
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] v, input bit lower);
      if (v < 4'd10) return nsf_pkg::CH_0 + 8'(v);
      return (lower ? nsf_pkg::CH_LA : nsf_pkg::CH_UA) + 8'(v) - 8'd10;
   endfunction

   task automatic frame_step(input logic [7:0] c);
      frame_result_type r;
      logic [4:0]       nib;
      r   = '0;
      nib = nibble_of(c);
      case (fr_phase)
         nsf_pkg::PH_IDLE: begin
            if (c == nsf_pkg::CH_DOLLAR) begin
               fr_phase      = nsf_pkg::PH_BODY;
               fr_body_count = 7'd0;
               fr_xor        = 8'h00;
            end
         end
         nsf_pkg::PH_BODY: begin
            if (fr_body_count < BODY_MAX) begin
               if (c != nsf_pkg::CH_STAR) begin
                  r.valid       = 1'b1;
                  r.data        = c;
                  r.index       = fr_body_count;
                  fr_xor        = fr_xor ^ c;
                  fr_body_count = fr_body_count + 7'd1;
               end else begin
                  fr_phase = nsf_pkg::PH_HEX1;
               end
            end else begin
               r.cause  = nsf_pkg::CAUSE_OVERLONG;
               fr_phase = nsf_pkg::PH_IDLE;
            end
         end
         nsf_pkg::PH_HEX1: begin
            if (nib[4]) begin
               fr_check = {nib[3:0], 4'h0};
               fr_phase = nsf_pkg::PH_HEX2;
            end else begin
               r.cause  = nsf_pkg::CAUSE_BADHEX;
               fr_phase = nsf_pkg::PH_IDLE;
            end
         end
         nsf_pkg::PH_HEX2: begin
            if (nib[4]) begin
               fr_check = {fr_check[7:4], nib[3:0]};
               if (fr_check == fr_xor) begin
                  fr_phase = nsf_pkg::PH_CR;
               end else begin
                  r.cause  = nsf_pkg::CAUSE_MISMATCH;
                  fr_phase = nsf_pkg::PH_IDLE;
               end
            end else begin
               r.cause  = nsf_pkg::CAUSE_BADHEX;
               fr_phase = nsf_pkg::PH_IDLE;
            end
         end
         nsf_pkg::PH_CR: begin
            if (c == nsf_pkg::CH_CR) begin
               fr_phase = nsf_pkg::PH_LF;
            end else begin
               r.cause  = nsf_pkg::CAUSE_LINEEND;
               fr_phase = nsf_pkg::PH_IDLE;
            end
         end
         nsf_pkg::PH_LF: begin
            if (c == nsf_pkg::CH_LF) begin
               r.good        = 1'b1;
               r.length      = fr_body_count;
               fr_good_count = fr_good_count + 8'd1;
            end else begin
               r.cause = nsf_pkg::CAUSE_LINEEND;
            end
            fr_phase = nsf_pkg::PH_IDLE;
         end
         default: fr_phase = nsf_pkg::PH_IDLE;
      endcase
      r.count = fr_good_count;
      frames_expected.push_back(r);
   endtask

   task automatic queue_byte(input logic [7:0] c, input bit counted);
      pending_bytes.push_back(c);
      if (counted) item_total++;
   endtask

   task automatic queue_sentence(input int len, input fault_type fault);
      logic [7:0] sum, c, bad, nib_bad;
      logic [4:0] nib;
      sum = 8'h00;
      do begin
         bad = 8'($urandom_range(0, 255));
         nib = nibble_of(bad);
      end while (nib[4]);
      nib_bad = 8'($urandom_range(0, 255));
      queue_byte(nsf_pkg::CH_DOLLAR, 1'b1);
      for (int i = 0; i < len; i++) begin
         case ($urandom_range(0, 7))
            0:       c = 8'($urandom_range(0, 255));
            1:       c = nsf_pkg::CH_DOLLAR;
            default: c = 8'($urandom_range(8'h20, 8'h7E));
         endcase
         if (c == nsf_pkg::CH_STAR) c = c ^ 8'h01;
         sum = sum ^ c;
         queue_byte(c, 1'b1);
      end
      queue_byte(nsf_pkg::CH_STAR, 1'b1);
      if (fault == FAULT_SUM) sum = sum ^ 8'($urandom_range(1, 255));
      queue_byte(fault == FAULT_HEX_HI ? bad : hex_char(sum[7:4], 1'($urandom_range(0, 1))),
                 1'b1);
      queue_byte(fault == FAULT_HEX_LO ? bad : hex_char(sum[3:0], 1'($urandom_range(0, 1))),
                 1'b1);
      if (fault == FAULT_CR)
         queue_byte(nib_bad == nsf_pkg::CH_CR ? nib_bad ^ 8'h01 : nib_bad, 1'b1);
      else queue_byte(nsf_pkg::CH_CR, 1'b1);
      if (fault == FAULT_LF)
         queue_byte(nib_bad == nsf_pkg::CH_LF ? nib_bad ^ 8'h01 : nib_bad, 1'b1);
      else queue_byte(nsf_pkg::CH_LF, 1'b1);
   endtask

   // driver
   always @(posedge clock) begin
      logic       offer;
      logic [7:0] next_data;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         offer     = 1'b0;
         next_data = req_tdata;
         if (req_tvalid) items_sent++;
         if (send_gap > 0) begin
            send_gap--;
         end else if (pending_bytes.size() > 0) begin
            if (!calm && hold_left == 0 && !cycle_count[8] && $urandom_range(0, 9) == 0) begin
               send_gap = $urandom_range(0, 18);
            end else begin
               offer     = 1'b1;
               next_data = pending_bytes.pop_front();
            end
         end
         req_tvalid <= offer;
         req_tdata  <= next_data;
      end
   end

   // receiver, with one long hold-off to back the framer up
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (!hold_done && items_sent >= HOLD_AFTER) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES - 1;
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (!calm && !cycle_count[8] && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(0, 18);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // monitor: predict on each req transfer, check on each rsp transfer
   always @(posedge clock) begin
      frame_result_type got, want;
      if (!reset) begin
         if (req_tvalid && req_tready) frame_step(req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (frames_expected.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected result transfer: rsp_tdata=%h", rsp_tdata);
            end else begin
               want = frames_expected.pop_front();
               if (got.valid !== want.valid || got.data !== want.data
                   || got.index !== want.index || got.good !== want.good
                   || got.length !== want.length || got.count !== want.count
                   || got.cause !== want.cause) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display({"result mismatch at cycle %0d: expected valid=%0d byte=%h ",
                               "index=%0d good=%0d length=%0d count=%0d cause=%0d, got ",
                               "valid=%0d byte=%h index=%0d good=%0d length=%0d ",
                               "count=%0d cause=%0d"},
                              cycle_count, want.valid, want.data, want.index, want.good,
                              want.length, want.count, want.cause, got.valid, got.data,
                              got.index, got.good, got.length, got.count, got.cause);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_nmea_sentence_framer failed");
         $finish;
      end
   end

   initial begin
      logic [7:0] opening[$];
      logic [7:0] c;
      int         len;
      opening = '{8'h00, 8'hFF,
                  nsf_pkg::CH_DOLLAR, "A", nsf_pkg::CH_STAR, "4", "1",
                  nsf_pkg::CH_CR, nsf_pkg::CH_LF,
                  nsf_pkg::CH_DOLLAR, nsf_pkg::CH_STAR, "G",
                  nsf_pkg::CH_DOLLAR, nsf_pkg::CH_STAR, "0", "1",
                  nsf_pkg::CH_DOLLAR, nsf_pkg::CH_DOLLAR, nsf_pkg::CH_STAR, "2", "4",
                  nsf_pkg::CH_CR, "X"};
      foreach (opening[i]) queue_byte(opening[i], 1'b1);
      while (item_total < ITEM_TARGET) begin
         case ($urandom_range(0, 19))
            0: begin
               len = $urandom_range(BODY_MAX - 1, BODY_MAX + 3);
               queue_sentence(len, fault_type'($urandom_range(0, 1) ? 0 : $urandom_range(0, 5)));
            end
            1, 2: begin
               repeat ($urandom_range(1, 3)) begin
                  c = 8'($urandom_range(0, 255));
                  if (c == nsf_pkg::CH_DOLLAR) c = c ^ 8'h01;
                  queue_byte(c, 1'b0);
               end
            end
            default: begin
               len = $urandom_range(0, 12);
               if ($urandom_range(0, 1)) queue_sentence(len, FAULT_NONE);
               else queue_sentence(len, fault_type'($urandom_range(0, 5)));
            end
         endcase
      end
      total_bytes = pending_bytes.size();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      while (pending_bytes.size() > 0 || req_tvalid) @(posedge clock);
      while (frames_expected.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && frames_expected.size() == 0) begin
         $display("tb_nmea_sentence_framer passed");
      end else begin
         $display("tb_nmea_sentence_framer failed");
      end
      $finish;
   end

endmodule

/* sim.f */
src/nsf_pkg.sv
src/nmea_sentence_framer.sv
sim/tb_nmea_sentence_framer.sv
